// ===== design/email_addr_spec_scanner_top_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the address scanner
// Shared property forms used by the checker that watches the top level.
// ---------------------------------------------------------------------------
`ifndef EMAIL_ADDR_SPEC_SCANNER_TOP_DEFINES_SVH
`define EMAIL_ADDR_SPEC_SCANNER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EASS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("address scanner check failed");

// The consequent must hold in the cycle after the antecedent.
`define EASS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("address scanner check failed");

`endif

// ===== design/eass_pkg.sv =====
// ---------------------------------------------------------------------------
// eass_pkg
// Types, character codes and limits shared by the address scanner modules.
// ---------------------------------------------------------------------------
package eass_pkg;

  localparam int MAX_COMMENT_DEPTH = 15;
  localparam int MAX_BUFFER_BYTES  = 65535;

  // Comment depth lives in four bits, the byte count in sixteen.
  localparam int DEPTH_CAP = (MAX_COMMENT_DEPTH < 15) ? MAX_COMMENT_DEPTH : 15;
  localparam int COUNT_CAP = (MAX_BUFFER_BYTES < 65535) ? MAX_BUFFER_BYTES : 65535;

  localparam logic [8:0] KEPT_LIMIT_RESET = 9'd256;
  localparam logic [8:0] KEPT_SAT         = 9'd511;

  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  typedef enum logic [3:0] {
    ST_BEFORE   = 4'd0,
    ST_LSTART   = 4'd1,
    ST_LMID     = 4'd2,
    ST_LCOMMENT = 4'd3,
    ST_LQUOTED  = 4'd4,
    ST_EWSTART  = 4'd5,
    ST_EWMID    = 4'd6,
    ST_EWQM     = 4'd7,
    ST_EWEND    = 4'd8,
    ST_DSTART   = 4'd9,
    ST_DMID     = 4'd10,
    ST_DCOMMENT = 4'd11,
    ST_END      = 4'd12,
    ST_ERROR    = 4'd13
  } scan_state_t;

  typedef enum logic [1:0] {
    KIND_LOCAL   = 2'd0,
    KIND_DOMAIN  = 2'd1,
    KIND_SUMMARY = 2'd2
  } part_kind_t;

  // Everything one byte produces: up to two kept characters and a summary.
  typedef struct packed {
    logic [7:0]  char0;
    logic [7:0]  char1;
    part_kind_t  char_kind;
    logic [1:0]  n_chars;
    logic        summary;
    logic        addr_valid;
    logic        at_seen;
    logic        enc_word;
    logic [15:0] count;
  } packet_t;

endpackage

// ===== design/eass_scan.sv =====
// ---------------------------------------------------------------------------
// eass_scan
// Scanner state registers and the single-pass step logic for one byte.
// ---------------------------------------------------------------------------
module eass_scan (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [7:0]           data_byte,
  input  logic                 end_of_buffer,
  input  logic [8:0]           max_kept_length,
  output eass_pkg::packet_t    pkt
);

  eass_pkg::scan_state_t scan_state, scan_state_next;
  logic [3:0]  comment_depth, comment_depth_next;
  logic        escape_pending, escape_pending_next;
  logic        previous_was_dot, previous_was_dot_next;
  logic        at_flag, at_flag_next;
  logic        encoded_word_flag, encoded_word_flag_next;
  logic [8:0]  kept_length, kept_length_next;
  logic [15:0] consumed_bytes, consumed_bytes_next;

  eass_pkg::scan_state_t eff_state, final_state;
  logic        is_space, stopped, over, used;
  logic [3:0]  depth_inc, depth_dec;
  logic [9:0]  kept_sum;
  logic [7:0]  char0, char1;
  logic [1:0]  n_chars;
  eass_pkg::part_kind_t char_kind;

  assign is_space  = data_byte inside {eass_pkg::CH_SPACE, eass_pkg::CH_TAB,
                                       eass_pkg::CH_CR, eass_pkg::CH_LF};
  assign stopped   = (scan_state == eass_pkg::ST_END) || (scan_state == eass_pkg::ST_ERROR);
  assign over      = kept_length >= max_kept_length;
  // Before the address a non-space byte falls straight through to the local start.
  assign eff_state = (scan_state == eass_pkg::ST_BEFORE && !is_space) ?
                     eass_pkg::ST_LSTART : scan_state;
  assign depth_inc = (comment_depth < 4'(eass_pkg::DEPTH_CAP)) ?
                     comment_depth + 4'd1 : comment_depth;
  assign depth_dec = (comment_depth != 4'd0) ? comment_depth - 4'd1 : comment_depth;

  always_comb begin : next_state_logic
    scan_state_next        = scan_state;
    comment_depth_next     = comment_depth;
    escape_pending_next    = escape_pending;
    previous_was_dot_next  = previous_was_dot;
    at_flag_next           = at_flag;
    encoded_word_flag_next = encoded_word_flag;
    used                   = 1'b0;
    if (!stopped) begin
      if (over) begin
        scan_state_next = eass_pkg::ST_ERROR;
      end else begin
        case (eff_state)
          eass_pkg::ST_BEFORE: begin
            used = 1'b1;
          end
          eass_pkg::ST_LSTART: begin
            used = 1'b1;
            if (data_byte == eass_pkg::CH_DQUOTE) begin
              scan_state_next = eass_pkg::ST_LQUOTED;
            end else if (data_byte == eass_pkg::CH_EQUALS) begin
              scan_state_next = eass_pkg::ST_EWSTART;
            end else if (data_byte == eass_pkg::CH_LPAREN) begin
              scan_state_next    = eass_pkg::ST_LCOMMENT;
              comment_depth_next = depth_inc;
            end else begin
              scan_state_next = eass_pkg::ST_LMID;
            end
          end
          eass_pkg::ST_LCOMMENT, eass_pkg::ST_DCOMMENT: begin
            used = 1'b1;
            if (escape_pending) begin
              escape_pending_next = 1'b0;
            end else if (data_byte == eass_pkg::CH_BSLASH) begin
              escape_pending_next = 1'b1;
            end else if (data_byte == eass_pkg::CH_LPAREN) begin
              comment_depth_next = depth_inc;
            end else if (data_byte == eass_pkg::CH_RPAREN) begin
              comment_depth_next = depth_dec;
              if (depth_dec == 4'd0) begin
                scan_state_next = (eff_state == eass_pkg::ST_LCOMMENT) ?
                                  eass_pkg::ST_LMID : eass_pkg::ST_DMID;
              end
            end
          end
          eass_pkg::ST_LQUOTED: begin
            if (escape_pending) begin
              escape_pending_next = 1'b0;
              if (data_byte == eass_pkg::CH_DQUOTE || data_byte == eass_pkg::CH_BSLASH) begin
                used = 1'b1;
              end else begin
                scan_state_next = eass_pkg::ST_ERROR;
              end
            end else begin
              used = 1'b1;
              if (data_byte == eass_pkg::CH_DQUOTE) begin
                scan_state_next = eass_pkg::ST_LMID;
              end else if (data_byte == eass_pkg::CH_BSLASH) begin
                escape_pending_next = 1'b1;
              end
            end
          end
          eass_pkg::ST_EWSTART: begin
            used = 1'b1;
            if (data_byte == eass_pkg::CH_QMARK) begin
              scan_state_next        = eass_pkg::ST_EWMID;
              encoded_word_flag_next = 1'b1;
            end else begin
              scan_state_next = eass_pkg::ST_LMID;
            end
          end
          eass_pkg::ST_LMID: begin
            if (data_byte == eass_pkg::CH_DOT) begin
              previous_was_dot_next = 1'b1;
              used                  = 1'b1;
            end else if (data_byte == eass_pkg::CH_DQUOTE && previous_was_dot) begin
              previous_was_dot_next = 1'b0;
              scan_state_next       = eass_pkg::ST_LQUOTED;
              used                  = 1'b1;
            end else if (data_byte == eass_pkg::CH_LPAREN) begin
              scan_state_next    = eass_pkg::ST_LCOMMENT;
              comment_depth_next = depth_inc;
              used               = 1'b1;
            end else if (data_byte == eass_pkg::CH_AT) begin
              at_flag_next    = 1'b1;
              scan_state_next = eass_pkg::ST_DSTART;
              used            = 1'b1;
            end else if (is_space) begin
              scan_state_next = eass_pkg::ST_END;
            end else begin
              previous_was_dot_next = 1'b0;
              used                  = 1'b1;
            end
          end
          eass_pkg::ST_EWMID: begin
            used = 1'b1;
            if (data_byte == eass_pkg::CH_QMARK) begin
              scan_state_next = eass_pkg::ST_EWQM;
            end
          end
          eass_pkg::ST_EWQM: begin
            used            = 1'b1;
            scan_state_next = (data_byte == eass_pkg::CH_EQUALS) ?
                              eass_pkg::ST_EWEND : eass_pkg::ST_EWMID;
          end
          eass_pkg::ST_EWEND: begin
            if (data_byte == eass_pkg::CH_AT) begin
              at_flag_next    = 1'b1;
              scan_state_next = eass_pkg::ST_DSTART;
              used            = 1'b1;
            end else begin
              scan_state_next = eass_pkg::ST_END;
            end
          end
          eass_pkg::ST_DSTART: begin
            used = 1'b1;
            if (data_byte == eass_pkg::CH_LPAREN) begin
              scan_state_next    = eass_pkg::ST_DCOMMENT;
              comment_depth_next = depth_inc;
            end else begin
              scan_state_next = eass_pkg::ST_DMID;
            end
          end
          eass_pkg::ST_DMID: begin
            if (is_space) begin
              scan_state_next = eass_pkg::ST_END;
            end else if (data_byte == eass_pkg::CH_LPAREN) begin
              scan_state_next    = eass_pkg::ST_DCOMMENT;
              comment_depth_next = depth_inc;
              used               = 1'b1;
            end else begin
              used = 1'b1;
            end
          end
          default: begin
            scan_state_next = eass_pkg::ST_ERROR;
          end
        endcase
      end
    end
  end

  always_comb begin : output_logic
    char0     = data_byte;
    char1     = data_byte;
    n_chars   = 2'd0;
    char_kind = eass_pkg::KIND_LOCAL;
    if (!stopped && !over) begin
      case (eff_state)
        eass_pkg::ST_LSTART: begin
          if (!(data_byte inside {eass_pkg::CH_DQUOTE, eass_pkg::CH_EQUALS,
                                  eass_pkg::CH_LPAREN})) begin
            n_chars = 2'd1;
          end
        end
        eass_pkg::ST_LQUOTED: begin
          if (escape_pending) begin
            if (data_byte inside {eass_pkg::CH_DQUOTE, eass_pkg::CH_BSLASH}) begin
              n_chars = 2'd1;
            end
          end else if (!(data_byte inside {eass_pkg::CH_DQUOTE, eass_pkg::CH_BSLASH})) begin
            n_chars = 2'd1;
          end
        end
        eass_pkg::ST_EWSTART: begin
          char0   = eass_pkg::CH_EQUALS;
          n_chars = 2'd2;
        end
        eass_pkg::ST_LMID: begin
          if (data_byte == eass_pkg::CH_DOT) begin
            n_chars = 2'd1;
          end else if (!((data_byte == eass_pkg::CH_DQUOTE && previous_was_dot) ||
                         data_byte == eass_pkg::CH_LPAREN ||
                         data_byte == eass_pkg::CH_AT || is_space)) begin
            n_chars = 2'd1;
          end
        end
        eass_pkg::ST_EWMID: begin
          if (data_byte != eass_pkg::CH_QMARK) begin
            n_chars = 2'd1;
          end
        end
        eass_pkg::ST_EWQM: begin
          char0   = eass_pkg::CH_QMARK;
          n_chars = 2'd2;
        end
        eass_pkg::ST_DSTART: begin
          char_kind = eass_pkg::KIND_DOMAIN;
          if (data_byte != eass_pkg::CH_LPAREN) begin
            n_chars = 2'd1;
          end
        end
        eass_pkg::ST_DMID: begin
          char_kind = eass_pkg::KIND_DOMAIN;
          if (!is_space && data_byte != eass_pkg::CH_LPAREN) begin
            n_chars = 2'd1;
          end
        end
        default: begin
          n_chars = 2'd0;
        end
      endcase
    end
  end

  assign kept_sum         = {1'b0, kept_length} + {8'd0, n_chars};
  assign kept_length_next = (kept_sum > {1'b0, eass_pkg::KEPT_SAT}) ?
                            eass_pkg::KEPT_SAT : kept_sum[8:0];
  assign consumed_bytes_next = (used && consumed_bytes < 16'(eass_pkg::COUNT_CAP)) ?
                               consumed_bytes + 16'd1 : consumed_bytes;

  // A buffer that ends inside a plain local part or the domain is complete.
  assign final_state = (used && (scan_state_next == eass_pkg::ST_LMID ||
                                 scan_state_next == eass_pkg::ST_DMID)) ?
                       eass_pkg::ST_END : scan_state_next;

  always_comb begin
    pkt.char0      = char0;
    pkt.char1      = char1;
    pkt.char_kind  = char_kind;
    pkt.n_chars    = n_chars;
    pkt.summary    = end_of_buffer;
    pkt.addr_valid = (final_state == eass_pkg::ST_END);
    pkt.at_seen    = at_flag_next;
    pkt.enc_word   = encoded_word_flag_next;
    pkt.count      = consumed_bytes_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && end_of_buffer)) begin
      scan_state        <= eass_pkg::ST_BEFORE;
      comment_depth     <= 4'd0;
      escape_pending    <= 1'b0;
      previous_was_dot  <= 1'b0;
      at_flag           <= 1'b0;
      encoded_word_flag <= 1'b0;
      kept_length       <= 9'd0;
      consumed_bytes    <= 16'd0;
    end else if (step) begin
      scan_state        <= scan_state_next;
      comment_depth     <= comment_depth_next;
      escape_pending    <= escape_pending_next;
      previous_was_dot  <= previous_was_dot_next;
      at_flag           <= at_flag_next;
      encoded_word_flag <= encoded_word_flag_next;
      kept_length       <= kept_length_next;
      consumed_bytes    <= consumed_bytes_next;
    end
  end

endmodule

// ===== design/eass_out.sv =====
// ---------------------------------------------------------------------------
// eass_out
// Result register holding one byte's results and handing them out as beats.
// ---------------------------------------------------------------------------
module eass_out (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  eass_pkg::packet_t pkt,
  output logic              can_load,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [31:0]       m_axis_tdata,
  output logic [1:0]        m_axis_tuser,
  output logic              m_axis_tlast
);

  eass_pkg::packet_t pkt_q;
  logic       pkt_valid;
  logic [1:0] beat_idx;
  logic [1:0] total, total_in;
  logic       is_char, last_beat, taken;
  logic [7:0] cur_char;

  assign total     = pkt_q.n_chars + {1'b0, pkt_q.summary};
  assign total_in  = pkt.n_chars + {1'b0, pkt.summary};
  assign is_char   = beat_idx < pkt_q.n_chars;
  assign last_beat = beat_idx == (total - 2'd1);
  assign taken     = pkt_valid && m_axis_tready;
  assign can_load  = !pkt_valid || (taken && last_beat);
  assign cur_char  = beat_idx[0] ? pkt_q.char1 : pkt_q.char0;

  assign m_axis_tvalid = pkt_valid;
  assign m_axis_tlast  = !is_char;
  assign m_axis_tuser  = is_char ? pkt_q.char_kind : eass_pkg::KIND_SUMMARY;
  assign m_axis_tdata  = is_char ? {24'd0, cur_char} :
                         {5'd0, pkt_q.count, pkt_q.enc_word, pkt_q.at_seen,
                          pkt_q.addr_valid, 8'd0};

  always_ff @(posedge clk) begin
    if (rst) begin
      pkt_valid <= 1'b0;
      beat_idx  <= 2'd0;
    end else if (load && can_load) begin
      pkt_valid <= (total_in != 2'd0);
      beat_idx  <= 2'd0;
    end else if (taken) begin
      if (last_beat) begin
        pkt_valid <= 1'b0;
        beat_idx  <= 2'd0;
      end else begin
        beat_idx <= beat_idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      pkt_q <= pkt;
    end
  end

endmodule

// ===== design/email_addr_spec_scanner_top.sv =====
// ---------------------------------------------------------------------------
// email_addr_spec_scanner_top
// Streaming addr-spec scanner: bytes in, kept characters and a summary out.
// ---------------------------------------------------------------------------
// The block reads an e-mail address one byte per input beat, with tlast on
// the final byte of the buffer. Each kept local-part character leaves as a
// beat with tuser 0 and each domain character with tuser 1; on the final
// byte a summary beat follows (tuser 2, tlast high) carrying the valid flag,
// the '@'-seen flag, the encoded-word flag and the number of bytes consumed,
// after which the per-buffer state returns to its reset values. A byte
// passes from the input register through the scanner step into the result
// register; the step waits while the result register still holds beats of
// an earlier byte, and goes ahead while that byte's last beat is taken.
// The result port carries one beat per cycle while m_axis_tready is high:
// a byte with zero or one result gives at most one beat, and a byte with two
// or three results (encoded-word pairs, or a character plus the summary)
// holds the result register for all of its beats. The limit on kept
// characters is to be written through cfg_wr_en and cfg_wr_data while the
// block is idle; the block itself does not enforce this. It resets to 256.
// There is no memory and no clearing pass.
// ---------------------------------------------------------------------------
module email_addr_spec_scanner_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [8:0]  cfg_wr_data,    // max_kept_length
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // end_of_buffer
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] out_char, [8] address_valid, [9] at_seen, [10] local_encoded_word,
  // [26:11] consumed_count, [31:27] zero
  output logic [31:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,   // [1:0] part_kind
  output logic        m_axis_tlast    // last_result
);

  logic [8:0] max_kept_length;
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       can_load;
  logic       step;
  eass_pkg::packet_t pkt;

  // A byte is processed whenever the result register is free or emptying.
  assign step          = in_valid && can_load;
  assign s_axis_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_kept_length <= eass_pkg::KEPT_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      max_kept_length <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (step) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  eass_scan u_scan (
    .clk             (clk),
    .rst             (rst),
    .step            (step),
    .data_byte       (in_byte),
    .end_of_buffer   (in_last),
    .max_kept_length (max_kept_length),
    .pkt             (pkt)
  );

  eass_out u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (step),
    .pkt           (pkt),
    .can_load      (can_load),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ===== design/eass_checker.sv =====
// ---------------------------------------------------------------------------
// eass_checker
// Port-level checks on the result stream of the address scanner.
// ---------------------------------------------------------------------------
`include "email_addr_spec_scanner_top_defines.svh"

module eass_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  logic        tuser_summary;
  logic        summary_pad_zero;
  logic [34:0] beat;

  assign tuser_summary    = (m_axis_tuser == eass_pkg::KIND_SUMMARY);
  assign summary_pad_zero = (m_axis_tdata[7:0] == 8'd0) && (m_axis_tdata[31:27] == 5'd0);
  assign beat             = {m_axis_tlast, m_axis_tuser, m_axis_tdata};

  // Only the summary beat closes a buffer.
  `EASS_ASSERT_NOW(a_last_is_summary, clk, rst, m_axis_tvalid, m_axis_tlast == tuser_summary)

  // Character beats carry nothing above the character itself.
  `EASS_ASSERT_NOW(a_char_clean, clk, rst, m_axis_tvalid && !m_axis_tlast, m_axis_tdata[31:8] == 24'd0)

  // The summary carries no character and no stray padding.
  `EASS_ASSERT_NOW(a_summary_clean, clk, rst, m_axis_tvalid && m_axis_tlast, summary_pad_zero)

  // A stalled beat stays put.
  `EASS_ASSERT_NEXT(a_stall_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(beat))

endmodule

bind email_addr_spec_scanner_top eass_checker u_eass_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// ===== tb/email_addr_spec_scanner_top_test.sv =====
// ---------------------------------------------------------------------------
// email_addr_spec_scanner_top_test
// Self-checking bench for the streaming addr-spec scanner.
// ---------------------------------------------------------------------------
// The initial block queues address bytes and limit writes. A clocked driver
// offers the queued bytes on the slave stream, and a clocked monitor takes
// result beats off the master stream. Every accepted byte runs through a
// scanner kept inside the bench, which queues the beats that the byte must
// produce. The monitor compares each arriving beat field by field with the
// oldest queued beat. Both stream sides idle at random, the receiver holds
// off once for a long stretch, and the sender drains the block completely
// before every limit write and once more in the middle of the random part.
// ---------------------------------------------------------------------------
module email_addr_spec_scanner_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 8;       // quiet cycles before a limit write
  localparam int TAIL_CYCLES   = 20;      // wait after the last beat is due
  localparam int HOLD_AT       = 60;      // bytes accepted when the hold starts
  localparam int HOLD_CYCLES   = 150;
  localparam int CALM_FROM     = 110;     // bytes accepted: no idling between
  localparam int CALM_TO       = 160;
  localparam int RANDOM_BYTES  = 100;
  localparam int PHASE_BYTES   = 25;
  localparam int CYCLE_LIMIT   = 200000;

  typedef enum logic [1:0] {
    FEED_BYTE,
    FEED_CONFIG,
    FEED_DRAIN
  } feed_kind_t;

  typedef struct {
    feed_kind_t kind;
    logic [8:0] value;
    logic       last;
  } feed_item_t;

  // One result beat as the block should present it.
  typedef struct packed {
    logic [7:0]           ch;
    eass_pkg::part_kind_t kind;
    logic                 valid;
    logic                 at;
    logic                 enc;
    logic [15:0]          count;
    logic                 last;
  } scan_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [8:0]  cfg_wr_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  feed_item_t  input_beats[$];
  scan_beat_t  expected_beats[$];
  logic [7:0]  addr_text[$];

  // The bench's own copy of the scanner state and of the limit register.
  eass_pkg::scan_state_t scan_st = eass_pkg::ST_BEFORE;
  logic [3:0]  nest_depth = '0;
  logic        escaping = 1'b0;
  logic        after_dot = 1'b0;
  logic        saw_at = 1'b0;
  logic        saw_enc = 1'b0;
  logic [8:0]  kept_count = '0;
  logic [15:0] used_count = '0;
  logic [8:0]  kept_limit = eass_pkg::KEPT_LIMIT_RESET;

  int queued_bytes = 0;
  int items_accepted = 0;
  int quiet_cycles = 0;
  int settings_used = 0;
  int chars_seen = 0;
  int summaries_seen = 0;
  int mismatches = 0;
  int hold_left = 0;
  int cycle_count = 0;
  bit hold_done = 0;
  bit feed_empty = 0;
  logic calm;

  assign calm = (items_accepted >= CALM_FROM) && (items_accepted < CALM_TO);

  email_addr_spec_scanner_top DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // -------------------------------------------------------------------------
  // Scanner prediction
  // -------------------------------------------------------------------------

  function automatic bit is_space(logic [7:0] c);
    return c == eass_pkg::CH_SPACE || c == eass_pkg::CH_TAB ||
           c == eass_pkg::CH_CR || c == eass_pkg::CH_LF;
  endfunction

  function automatic void reset_scan();
    scan_st    = eass_pkg::ST_BEFORE;
    nest_depth = '0;
    escaping   = 1'b0;
    after_dot  = 1'b0;
    saw_at     = 1'b0;
    saw_enc    = 1'b0;
    kept_count = '0;
    used_count = '0;
  endfunction

  // Queues a kept character beat and bumps the saturating kept count.
  function automatic void keep_char(logic [7:0] c, eass_pkg::part_kind_t kind);
    scan_beat_t b;
    b = '0;
    b.ch = c;
    b.kind = kind;
    expected_beats.push_back(b);
    if (kept_count < eass_pkg::KEPT_SAT) kept_count++;
  endfunction

  function automatic void deepen();
    if (nest_depth < eass_pkg::DEPTH_CAP) nest_depth++;
  endfunction

  // One byte inside a comment; true when the comment closes.
  function automatic bit comment_byte(logic [7:0] c);
    if (escaping) begin
      escaping = 1'b0;
    end else if (c == eass_pkg::CH_BSLASH) begin
      escaping = 1'b1;
    end else if (c == eass_pkg::CH_LPAREN) begin
      deepen();
    end else if (c == eass_pkg::CH_RPAREN) begin
      if (nest_depth > 0) nest_depth--;
      return nest_depth == 0;
    end
    return 1'b0;
  endfunction

  // Runs one accepted byte through the scanner and queues its beats. A byte
  // may pass through several states without being consumed, but is
  // consumed at most once.
  function automatic void scan_byte(logic [7:0] c, logic last);
    bit used;
    int step;
    scan_beat_t summary;
    used = 1'b0;
    for (step = 0; step < 4 && !used; step++) begin
      if (scan_st == eass_pkg::ST_END || scan_st == eass_pkg::ST_ERROR) break;
      if (kept_count >= kept_limit) begin
        scan_st = eass_pkg::ST_ERROR;
        break;
      end
      case (scan_st)
        eass_pkg::ST_BEFORE: begin
          if (is_space(c)) used = 1'b1;
          else scan_st = eass_pkg::ST_LSTART;
        end
        eass_pkg::ST_LSTART: begin
          used = 1'b1;
          if (c == eass_pkg::CH_DQUOTE) begin
            scan_st = eass_pkg::ST_LQUOTED;
          end else if (c == eass_pkg::CH_EQUALS) begin
            scan_st = eass_pkg::ST_EWSTART;
          end else if (c == eass_pkg::CH_LPAREN) begin
            scan_st = eass_pkg::ST_LCOMMENT;
            deepen();
          end else begin
            scan_st = eass_pkg::ST_LMID;
            keep_char(c, eass_pkg::KIND_LOCAL);
          end
        end
        eass_pkg::ST_LCOMMENT: begin
          used = 1'b1;
          if (comment_byte(c)) scan_st = eass_pkg::ST_LMID;
        end
        eass_pkg::ST_LQUOTED: begin
          if (escaping) begin
            // Only a quote or a backslash may follow the backslash.
            escaping = 1'b0;
            if (c == eass_pkg::CH_DQUOTE || c == eass_pkg::CH_BSLASH) begin
              keep_char(c, eass_pkg::KIND_LOCAL);
              used = 1'b1;
            end else begin
              scan_st = eass_pkg::ST_ERROR;
            end
          end else begin
            used = 1'b1;
            if (c == eass_pkg::CH_DQUOTE) scan_st = eass_pkg::ST_LMID;
            else if (c == eass_pkg::CH_BSLASH) escaping = 1'b1;
            else keep_char(c, eass_pkg::KIND_LOCAL);
          end
        end
        eass_pkg::ST_EWSTART: begin
          used = 1'b1;
          keep_char(eass_pkg::CH_EQUALS, eass_pkg::KIND_LOCAL);
          if (c == eass_pkg::CH_QMARK) begin
            scan_st = eass_pkg::ST_EWMID;
            keep_char(eass_pkg::CH_QMARK, eass_pkg::KIND_LOCAL);
            saw_enc = 1'b1;
          end else begin
            scan_st = eass_pkg::ST_LMID;
            keep_char(c, eass_pkg::KIND_LOCAL);
          end
        end
        eass_pkg::ST_LMID: begin
          if (c == eass_pkg::CH_DOT) begin
            after_dot = 1'b1;
            keep_char(c, eass_pkg::KIND_LOCAL);
            used = 1'b1;
          end else if (c == eass_pkg::CH_DQUOTE && after_dot) begin
            after_dot = 1'b0;
            scan_st = eass_pkg::ST_LQUOTED;
            used = 1'b1;
          end else if (c == eass_pkg::CH_LPAREN) begin
            scan_st = eass_pkg::ST_LCOMMENT;
            deepen();
            used = 1'b1;
          end else if (c == eass_pkg::CH_AT) begin
            saw_at = 1'b1;
            scan_st = eass_pkg::ST_DSTART;
            used = 1'b1;
          end else if (is_space(c)) begin
            scan_st = eass_pkg::ST_END;
          end else begin
            after_dot = 1'b0;
            keep_char(c, eass_pkg::KIND_LOCAL);
            used = 1'b1;
          end
        end
        eass_pkg::ST_EWMID: begin
          used = 1'b1;
          if (c == eass_pkg::CH_QMARK) scan_st = eass_pkg::ST_EWQM;
          else keep_char(c, eass_pkg::KIND_LOCAL);
        end
        eass_pkg::ST_EWQM: begin
          used = 1'b1;
          keep_char(eass_pkg::CH_QMARK, eass_pkg::KIND_LOCAL);
          if (c == eass_pkg::CH_EQUALS) begin
            scan_st = eass_pkg::ST_EWEND;
            keep_char(eass_pkg::CH_EQUALS, eass_pkg::KIND_LOCAL);
          end else begin
            scan_st = eass_pkg::ST_EWMID;
            keep_char(c, eass_pkg::KIND_LOCAL);
          end
        end
        eass_pkg::ST_EWEND: begin
          if (c == eass_pkg::CH_AT) begin
            saw_at = 1'b1;
            scan_st = eass_pkg::ST_DSTART;
            used = 1'b1;
          end else begin
            scan_st = eass_pkg::ST_END;
          end
        end
        eass_pkg::ST_DSTART: begin
          used = 1'b1;
          if (c == eass_pkg::CH_LPAREN) begin
            scan_st = eass_pkg::ST_DCOMMENT;
            deepen();
          end else begin
            scan_st = eass_pkg::ST_DMID;
            keep_char(c, eass_pkg::KIND_DOMAIN);
          end
        end
        eass_pkg::ST_DMID: begin
          if (is_space(c)) begin
            scan_st = eass_pkg::ST_END;
          end else if (c == eass_pkg::CH_LPAREN) begin
            scan_st = eass_pkg::ST_DCOMMENT;
            deepen();
            used = 1'b1;
          end else begin
            keep_char(c, eass_pkg::KIND_DOMAIN);
            used = 1'b1;
          end
        end
        eass_pkg::ST_DCOMMENT: begin
          used = 1'b1;
          if (comment_byte(c)) scan_st = eass_pkg::ST_DMID;
        end
        default: scan_st = eass_pkg::ST_ERROR;
      endcase
    end

    if (used && used_count < eass_pkg::COUNT_CAP) used_count++;

    if (last) begin
      // A consumed final byte closes a plain local part or a domain part.
      if (used && (scan_st == eass_pkg::ST_DMID || scan_st == eass_pkg::ST_LMID))
        scan_st = eass_pkg::ST_END;
      summary = '0;
      summary.kind  = eass_pkg::KIND_SUMMARY;
      summary.valid = (scan_st == eass_pkg::ST_END);
      summary.at    = saw_at;
      summary.enc   = saw_enc;
      summary.count = used_count;
      summary.last  = 1'b1;
      expected_beats.push_back(summary);
      reset_scan();
    end
  endfunction

  // -------------------------------------------------------------------------
  // Stimulus building
  // -------------------------------------------------------------------------

  function automatic void add_byte(logic [7:0] c, logic last);
    feed_item_t f;
    f.kind = FEED_BYTE;
    f.value = {1'b0, c};
    f.last = last;
    input_beats.push_back(f);
    queued_bytes++;
  endfunction

  function automatic void add_marker(feed_kind_t kind, logic [8:0] value);
    feed_item_t f;
    f.kind = kind;
    f.value = value;
    f.last = 1'b0;
    input_beats.push_back(f);
  endfunction

  function automatic void add_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) add_byte(s[i], i == s.len() - 1);
  endfunction

  function automatic logic [7:0] atom_char();
    string pool;
    pool = "abcdefghijklmnopqrstuvwxyzAZ0189-_+~!#";
    return pool[$urandom_range(pool.len() - 1)];
  endfunction

  function automatic logic [7:0] space_char();
    case ($urandom_range(3))
      0: return eass_pkg::CH_SPACE;
      1: return eass_pkg::CH_TAB;
      2: return eass_pkg::CH_CR;
      default: return eass_pkg::CH_LF;
    endcase
  endfunction

  function automatic void put_atoms();
    int n;
    n = $urandom_range(1, 3);
    for (int a = 0; a < n; a++) begin
      if (a > 0) addr_text.push_back(eass_pkg::CH_DOT);
      repeat ($urandom_range(1, 4)) addr_text.push_back(atom_char());
    end
  endfunction

  // Nested comments, now and then deep enough to saturate the depth count.
  function automatic void put_comment();
    int d;
    d = ($urandom_range(9) == 0) ? $urandom_range(15, 18) : $urandom_range(1, 2);
    repeat (d) begin
      addr_text.push_back(eass_pkg::CH_LPAREN);
      if ($urandom_range(2) == 0) addr_text.push_back(atom_char());
    end
    if ($urandom_range(3) == 0) begin
      addr_text.push_back(eass_pkg::CH_BSLASH);
      addr_text.push_back(eass_pkg::CH_RPAREN);
    end
    repeat (d) addr_text.push_back(eass_pkg::CH_RPAREN);
  endfunction

  function automatic void put_quoted();
    addr_text.push_back(eass_pkg::CH_DQUOTE);
    repeat ($urandom_range(1, 5)) begin
      if ($urandom_range(4) == 0) begin
        addr_text.push_back(eass_pkg::CH_BSLASH);
        case ($urandom_range(5))
          0, 1: addr_text.push_back(eass_pkg::CH_DQUOTE);
          2, 3: addr_text.push_back(eass_pkg::CH_BSLASH);
          default: addr_text.push_back(atom_char());  // bad escape
        endcase
      end else if ($urandom_range(7) == 0) begin
        addr_text.push_back(space_char());
      end else begin
        addr_text.push_back(atom_char());
      end
    end
    addr_text.push_back(eass_pkg::CH_DQUOTE);
  endfunction

  function automatic void put_encoded();
    addr_text.push_back(eass_pkg::CH_EQUALS);
    addr_text.push_back(eass_pkg::CH_QMARK);
    repeat ($urandom_range(1, 6)) begin
      // A lone question mark inside the word is kept along with its follower.
      if ($urandom_range(4) == 0) addr_text.push_back(eass_pkg::CH_QMARK);
      addr_text.push_back(atom_char());
    end
    if ($urandom_range(7) != 0) begin
      addr_text.push_back(eass_pkg::CH_QMARK);
      addr_text.push_back(eass_pkg::CH_EQUALS);
    end
  endfunction

  // Mostly well-formed addresses with random content; the rest is noise,
  // bad escapes and cut-off text.
  function automatic void add_address();
    int i;
    addr_text.delete();
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(1, 6)) addr_text.push_back(8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(0, 2)) addr_text.push_back(space_char());
      case ($urandom_range(4))
        0: put_atoms();
        1: put_quoted();
        2: put_encoded();
        3: begin
          put_comment();
          put_atoms();
        end
        default: begin
          addr_text.push_back(eass_pkg::CH_EQUALS);
          put_atoms();
        end
      endcase
      if ($urandom_range(3) == 0) begin
        addr_text.push_back(eass_pkg::CH_DOT);
        put_quoted();
      end
      if ($urandom_range(4) == 0) put_comment();
      if ($urandom_range(99) < 80) begin
        addr_text.push_back(eass_pkg::CH_AT);
        if ($urandom_range(3) == 0) put_comment();
        put_atoms();
        if ($urandom_range(3) == 0) put_comment();
      end
      if ($urandom_range(4) == 0) begin
        addr_text.push_back(space_char());
        put_atoms();
      end
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          if (addr_text.size() > 1) void'(addr_text.pop_back());
        end
      end
    end
    for (i = 0; i < addr_text.size(); i++) add_byte(addr_text[i], i == addr_text.size() - 1);
  endfunction

  // -------------------------------------------------------------------------
  // Result checking
  // -------------------------------------------------------------------------

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // -------------------------------------------------------------------------
  // Stimulus sequence and end of run
  // -------------------------------------------------------------------------

  initial begin : stimulus
    int phase;
    int phase_start;
    int random_start;
    logic [8:0] limit;

    // Directed part. Leading CR and LF, an encoded word with a lone question
    // mark, its closing pair and a domain part.
    add_text("\r\n=?a?b?=@d");
    // A lone equals sign followed by an ordinary character.
    add_text("=x");
    // Extreme byte values, first without and then with the end mark.
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b1);
    // A backslash in a quoted string followed by a character it cannot escape.
    add_text("\"a\\q\"");
    // A space stops the scanner; the remaining byte is not consumed.
    add_text("a b");

    // A limit of zero fails the address at its very first byte.
    add_marker(FEED_CONFIG, 9'd0);
    add_text(" ab");
    // With a limit of one, the equals-question pair overshoots it by one.
    add_marker(FEED_CONFIG, 9'd1);
    add_text("=?x");
    // A mid-range limit, reached by one long local part.
    add_marker(FEED_CONFIG, 9'd32);
    for (int i = 0; i < 34; i++) add_byte(atom_char(), i == 33);

    // Random part, in phases with a fresh limit each.
    random_start = queued_bytes;
    phase = 0;
    while (queued_bytes - random_start < RANDOM_BYTES) begin
      case (phase % 4)
        0: limit = 9'd256;
        1: limit = 9'($urandom_range(1, 8));
        2: limit = 9'($urandom_range(9, 60));
        default: limit = 9'($urandom_range(61, 256));
      endcase
      add_marker(FEED_CONFIG, limit);
      phase_start = queued_bytes;
      while (queued_bytes - phase_start < PHASE_BYTES) begin
        add_address();
        // Once, the sender waits for the block to run dry mid-phase.
        if (phase == 2 && queued_bytes - phase_start >= PHASE_BYTES / 2 &&
            queued_bytes - phase_start - addr_text.size() < PHASE_BYTES / 2)
          add_marker(FEED_DRAIN, '0);
      end
      phase++;
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (!(feed_empty && expected_beats.size() == 0));
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Scanned %0d bytes in %0d buffers, %0d kept characters, over %0d limit settings.",
             items_accepted, summaries_seen, chars_seen, settings_used);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // -------------------------------------------------------------------------
  // Driver: offers queued bytes and performs limit writes when idle.
  // -------------------------------------------------------------------------
  // All next values are worked out in variables first, so that each port
  // gets exactly one nonblocking assignment per edge.
  always @(posedge clk) begin : driver
    feed_item_t head;
    logic       nvalid;
    logic [7:0] ndata;
    logic       nlast;
    logic       ncfg;
    logic [8:0] ncfg_data;
    nvalid = s_axis_tvalid;
    ndata = s_axis_tdata;
    nlast = s_axis_tlast;
    ncfg = 1'b0;
    ncfg_data = cfg_wr_data;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        scan_byte(s_axis_tdata, s_axis_tlast);
        items_accepted++;
        nvalid = 1'b0;
      end
      // Counts cycles with nothing offered and no beat outstanding; a byte
      // that yields no beat may still be in flight while they are counted.
      if (expected_beats.size() == 0 && !s_axis_tvalid) quiet_cycles++;
      else quiet_cycles = 0;
      if (!nvalid && input_beats.size() > 0) begin
        head = input_beats[0];
        case (head.kind)
          FEED_CONFIG: begin
            if (quiet_cycles >= SETTLE_CYCLES) begin
              ncfg = 1'b1;
              ncfg_data = head.value;
              kept_limit = head.value;
              settings_used++;
              void'(input_beats.pop_front());
            end
          end
          FEED_DRAIN: begin
            if (quiet_cycles >= SETTLE_CYCLES) void'(input_beats.pop_front());
          end
          default: begin
            if (calm || $urandom_range(99) >= 32) begin
              nvalid = 1'b1;
              ndata = head.value[7:0];
              nlast = head.last;
              void'(input_beats.pop_front());
            end
          end
        endcase
      end
      feed_empty = (input_beats.size() == 0) && !nvalid;
    end
    s_axis_tvalid <= nvalid;
    s_axis_tdata <= ndata;
    s_axis_tlast <= nlast;
    cfg_wr_en <= ncfg;
    cfg_wr_data <= ncfg_data;
  end

  // -------------------------------------------------------------------------
  // Monitor: takes result beats and checks them against the queue.
  // -------------------------------------------------------------------------
  // The hold-off is counted here, so the sender keeps offering bytes and
  // the block has to stall its input once its result side backs up.
  always @(posedge clk) begin : monitor
    scan_beat_t want;
    logic       nready;
    nready = 1'b0;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_beats.size() == 0) begin
          $error("result beat with no expected beat waiting: tdata %h tuser %0d",
                 m_axis_tdata, m_axis_tuser);
          mismatches++;
        end else begin
          want = expected_beats.pop_front();
          check_field("out_char", want.ch, m_axis_tdata[7:0]);
          check_field("part_kind", want.kind, m_axis_tuser);
          check_field("address_valid", want.valid, m_axis_tdata[8]);
          check_field("at_seen", want.at, m_axis_tdata[9]);
          check_field("local_encoded_word", want.enc, m_axis_tdata[10]);
          check_field("consumed_count", want.count, m_axis_tdata[26:11]);
          check_field("tdata padding", 0, m_axis_tdata[31:27]);
          check_field("last_result", want.last, m_axis_tlast);
          if (want.kind == eass_pkg::KIND_SUMMARY) summaries_seen++;
          else chars_seen++;
        end
      end
      if (!hold_done && items_accepted >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        nready = 1'b0;
      end else begin
        nready = calm || ($urandom_range(99) >= 32);
      end
    end
    m_axis_tready <= nready;
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d beats outstanding.",
               cycle_count, expected_beats.size());
      $display("Some tests failed");
      $finish;
    end
  end

endmodule

// ===== sim.f =====
+incdir+design
design/eass_pkg.sv
design/eass_scan.sv
design/eass_out.sv
design/email_addr_spec_scanner_top.sv
design/eass_checker.sv
tb/email_addr_spec_scanner_top_test.sv
